[sv/kslpd_pkg.sv]
// ----------------------------------------------------------------------------
// kslpd_pkg: shared types and constants of the key press detector
// Item structs, command and action codes, flag bit positions and the
// per-key command struct that the top level hands to each key cell.
// ----------------------------------------------------------------------------
`default_nettype none

package kslpd_pkg;

    // Widths fixed by the item and register formats.
    localparam int TIMER_W   = 16;
    localparam int FLAGS_W   = 5;
    localparam int MASK_W    = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Saturation limit of the press timer.
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Register reset values.
    localparam logic [TIMER_W-1:0] SHORT_TIME_RST = 16'd50;
    localparam logic [TIMER_W-1:0] LONG_TIME_RST  = 16'd1000;
    localparam logic [MASK_W-1:0]  LONG_MODE_RST  = 4'h0;
    localparam logic [MASK_W-1:0]  ENABLE_RST     = 4'hF;

    // Flag bit positions.
    localparam int FL_FIRST = 0;
    localparam int FL_SHOLD = 1;
    localparam int FL_SREL  = 2;
    localparam int FL_LHOLD = 3;
    localparam int FL_LREL  = 4;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_RESET = 2'd2,
        KIND_CHECK = 2'd3
    } kslpd_kind_t;

    typedef enum logic [2:0] {
        ACT_NONE          = 3'd0,
        ACT_FIRST_PRESS   = 3'd1,
        ACT_SHORT_HOLD    = 3'd2,
        ACT_SHORT_RELEASE = 3'd3,
        ACT_LONG_HOLD     = 3'd4,
        ACT_LONG_RELEASE  = 3'd5
    } kslpd_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_TIME = 2'd0,
        CFG_LONG_TIME  = 2'd1,
        CFG_LONG_MODE  = 2'd2,
        CFG_ENABLE     = 2'd3
    } kslpd_cfg_idx_t;

    typedef struct packed {
        kslpd_kind_t       kind;
        logic [MASK_W-1:0] key_levels;
        logic [1:0]        key_index;
    } kslpd_in_t;

    typedef struct packed {
        kslpd_action_t     action;
        logic              action_pending;
        logic [MASK_W-1:0] pending_mask;
    } kslpd_out_t;

    // Command from the top level to one key cell for the current item.
    typedef struct packed {
        logic               tick;
        logic               read;
        logic               clear;
        logic               level;
        logic               enabled;
        logic               long_mode;
        logic [TIMER_W-1:0] short_time;
        logic [TIMER_W-1:0] long_time;
    } kslpd_key_cmd_t;

endpackage

`default_nettype wire

[sv/kslpd_key.sv]
// ----------------------------------------------------------------------------
// kslpd_key: state and classification logic of one key
// Holds the press timer and the action flags of one key, applies a tick,
// read or clear command and reports the flags after the command.
// ----------------------------------------------------------------------------
`default_nettype none

module kslpd_key
    import kslpd_pkg::*;
#(
    parameter int TICK_MS = 10
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire kslpd_key_cmd_t cmd,
    output logic [FLAGS_W-1:0]  flags_after,
    output kslpd_action_t       read_action
);

    localparam logic [TIMER_W:0] TICK_INC = (TIMER_W+1)'(TICK_MS);

    logic [TIMER_W-1:0] timer_reg;
    logic [TIMER_W-1:0] timer_next;
    logic [FLAGS_W-1:0] flags_reg;
    logic [FLAGS_W-1:0] flags_next;
    logic [TIMER_W:0]   timer_sum;
    logic [TIMER_W-1:0] timer_sat;

    // Timer increment with saturation.
    assign timer_sum = {1'b0, timer_reg} + TICK_INC;
    assign timer_sat = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];

    // Highest-priority latched action of this key.
    always_comb begin
        if (flags_reg[FL_FIRST]) begin
            read_action = ACT_FIRST_PRESS;
        end else if (flags_reg[FL_SHOLD]) begin
            read_action = ACT_SHORT_HOLD;
        end else if (flags_reg[FL_LHOLD]) begin
            read_action = ACT_LONG_HOLD;
        end else if (flags_reg[FL_SREL]) begin
            read_action = ACT_SHORT_RELEASE;
        end else if (flags_reg[FL_LREL]) begin
            read_action = ACT_LONG_RELEASE;
        end else begin
            read_action = ACT_NONE;
        end
    end

    // Next state for the command of the current item.
    always_comb begin
        timer_next = timer_reg;
        flags_next = flags_reg;
        if (cmd.tick) begin
            if (!cmd.enabled) begin
                flags_next = '0;
            end else if (timer_reg < cmd.short_time) begin
                timer_next = cmd.level ? timer_sat : '0;
            end else if (flags_reg == '0) begin
                flags_next[FL_FIRST] = 1'b1;
                flags_next[FL_SHOLD] = 1'b1;
            end else if (!cmd.long_mode) begin
                if (cmd.level) begin
                    flags_next[FL_SHOLD] = 1'b1;
                end else begin
                    timer_next          = '0;
                    flags_next[FL_SREL] = 1'b1;
                end
            end else if (timer_reg < cmd.long_time) begin
                if (cmd.level) begin
                    timer_next = timer_sat;
                end else begin
                    timer_next          = '0;
                    flags_next[FL_SREL] = 1'b1;
                end
            end else begin
                if (cmd.level) begin
                    flags_next[FL_LHOLD] = 1'b1;
                end else begin
                    timer_next          = '0;
                    flags_next[FL_LREL] = 1'b1;
                end
            end
        end else if (cmd.read) begin
            // A read consumes flags in priority order; a hold flag stays
            // until a later flag shows that the hold has ended.
            if (flags_reg[FL_FIRST]) begin
                flags_next[FL_FIRST] = 1'b0;
            end else if (flags_reg[FL_SHOLD]) begin
                if (flags_reg[FL_SREL] || flags_reg[FL_LREL] || flags_reg[FL_LHOLD]) begin
                    flags_next[FL_SHOLD] = 1'b0;
                end
            end else if (flags_reg[FL_LHOLD]) begin
                if (flags_reg[FL_SREL] || flags_reg[FL_LREL]) begin
                    flags_next[FL_LHOLD] = 1'b0;
                end
            end else if (flags_reg[FL_SREL] || flags_reg[FL_LREL]) begin
                flags_next = '0;
            end
        end else if (cmd.clear) begin
            timer_next = '0;
            flags_next = '0;
        end
    end

    assign flags_after = flags_next;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            flags_reg <= '0;
        end else begin
            timer_reg <= timer_next;
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

[sv/key_short_long_press_detector_top.sv]
// ----------------------------------------------------------------------------
// key_short_long_press_detector_top: short and long key press classifier
// The result of an item is registered and valid in the cycle after it is accepted.
// Throughput: one item per cycle unless m_ready stalls; the per-key update and the
// result selection sit between the input handshake and the result register.
// Reset: synchronous active-low aresetn clears all timers and flags and
// loads the default thresholds and masks; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module key_short_long_press_detector_top
    import kslpd_pkg::*;
#(
    parameter int NUM_KEYS = 4,
    parameter int TICK_MS  = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // Input item channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire kslpd_in_t            s_data,
    // Result item channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output kslpd_out_t                m_data
);

    // Keys at index four and above never hold flags, so only the first
    // four keys get storage.
    localparam int STORED_KEYS = (NUM_KEYS < MASK_W) ? NUM_KEYS : MASK_W;

    logic [TIMER_W-1:0] short_time_reg;
    logic [TIMER_W-1:0] long_time_reg;
    logic [MASK_W-1:0]  long_mode_reg;
    logic [MASK_W-1:0]  enable_reg;

    logic               accept;
    logic               m_valid_reg;
    kslpd_out_t         m_data_reg;
    kslpd_out_t         result;

    logic [MASK_W-1:0]  pending_vec;
    kslpd_action_t      action_vec [MASK_W];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_time_reg <= SHORT_TIME_RST;
            long_time_reg  <= LONG_TIME_RST;
            long_mode_reg  <= LONG_MODE_RST;
            enable_reg     <= ENABLE_RST;
        end else if (cfg_we) begin
            unique case (kslpd_cfg_idx_t'(cfg_index))
                CFG_SHORT_TIME: short_time_reg <= cfg_wdata[TIMER_W-1:0];
                CFG_LONG_TIME:  long_time_reg  <= cfg_wdata[TIMER_W-1:0];
                CFG_LONG_MODE:  long_mode_reg  <= cfg_wdata[MASK_W-1:0];
                CFG_ENABLE:     enable_reg     <= cfg_wdata[MASK_W-1:0];
                default:        ;
            endcase
        end
    end

    // An item enters whenever the result register is free or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // One cell per stored key; missing keys read as idle.
    for (genvar k = 0; k < MASK_W; k++) begin : g_key
        if (k < STORED_KEYS) begin : g_cell
            kslpd_key_cmd_t     cmd;
            logic [FLAGS_W-1:0] flags_after;

            always_comb begin
                cmd.tick       = accept && (s_data.kind == KIND_TICK);
                cmd.read       = accept && (s_data.kind == KIND_READ)
                                 && (s_data.key_index == 2'(k));
                cmd.clear      = accept && (s_data.kind == KIND_RESET)
                                 && (s_data.key_index == 2'(k));
                cmd.level      = s_data.key_levels[k];
                cmd.enabled    = enable_reg[k];
                cmd.long_mode  = long_mode_reg[k];
                cmd.short_time = short_time_reg;
                cmd.long_time  = long_time_reg;
            end

            kslpd_key #(
                .TICK_MS (TICK_MS)
            ) u_key (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .flags_after (flags_after),
                .read_action (action_vec[k])
            );

            assign pending_vec[k] = |flags_after;
        end else begin : g_none
            assign pending_vec[k] = 1'b0;
            assign action_vec[k]  = ACT_NONE;
        end
    end

    // Result of the item being accepted.
    always_comb begin
        result.action         = (s_data.kind == KIND_READ) ? action_vec[s_data.key_index]
                                                           : ACT_NONE;
        result.action_pending = pending_vec[s_data.key_index];
        result.pending_mask   = pending_vec;
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for key_short_long_press_detector_top
// Sends tick, read, reset and check items through the valid/ready input
// channel and compares every result item against a cycle-free predictor of
// the per-key press timers and action flags. Both channels idle and stall at
// random, and the thresholds and masks are rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
    import kslpd_pkg::*;

    localparam int KEYS        = 4;
    localparam int TICK_MS     = 10;
    localparam int RUN_LIMIT   = 50_000_000;
    localparam int MAX_REPORTS = 100;

    // One pending input item; hold_back makes the sender wait for all results.
    typedef struct {
        kslpd_in_t item;
        bit        hold_back;
    } key_item_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    kslpd_in_t            s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    kslpd_out_t           m_data;

    // Predictor state: per-key hold time and latched flags, plus registers.
    logic [TIMER_W-1:0] hold_ms   [KEYS];
    logic [FLAGS_W-1:0] key_flags [KEYS];
    logic [TIMER_W-1:0] short_ms_reg;
    logic [TIMER_W-1:0] long_ms_reg;
    logic [MASK_W-1:0]  long_mode_reg;
    logic [MASK_W-1:0]  enable_reg;

    key_item_t  key_item_q[$];
    kslpd_out_t report_q[$];
    kslpd_out_t want_res;

    int  items_sent_total = 0;
    int  results_seen     = 0;
    int  mismatch_count   = 0;
    int  send_gap         = 0;
    int  recv_hold        = 0;
    bit  send_quiet       = 1'b0;
    bit  recv_quiet       = 1'b0;
    bit  s_fire           = 1'b0;

    key_short_long_press_detector_top #(
        .NUM_KEYS (KEYS),
        .TICK_MS  (TICK_MS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Hold timer addition that saturates at the top of the timer range.
    function automatic logic [TIMER_W-1:0] add_tick(logic [TIMER_W-1:0] t);
        logic [TIMER_W:0] sum;
        sum = {1'b0, t} + (TIMER_W+1)'(TICK_MS);
        if (sum[TIMER_W]) begin
            return TIMER_MAX;
        end
        return sum[TIMER_W-1:0];
    endfunction

    // One tick of one enabled key.
    function automatic void time_key(int k, logic pressed, logic long_mode);
        if (hold_ms[k] < short_ms_reg) begin
            hold_ms[k] = pressed ? add_tick(hold_ms[k]) : '0;
        end else if (key_flags[k] == '0) begin
            key_flags[k][FL_FIRST] = 1'b1;
            key_flags[k][FL_SHOLD] = 1'b1;
        end else if (!long_mode) begin
            if (pressed) begin
                key_flags[k][FL_SHOLD] = 1'b1;
            end else begin
                hold_ms[k] = '0;
                key_flags[k][FL_SREL] = 1'b1;
            end
        end else if (hold_ms[k] < long_ms_reg) begin
            if (pressed) begin
                hold_ms[k] = add_tick(hold_ms[k]);
            end else begin
                hold_ms[k] = '0;
                key_flags[k][FL_SREL] = 1'b1;
            end
        end else begin
            if (pressed) begin
                key_flags[k][FL_LHOLD] = 1'b1;
            end else begin
                hold_ms[k] = '0;
                key_flags[k][FL_LREL] = 1'b1;
            end
        end
    endfunction

    // Highest-priority action of one key; hold flags are kept until a later
    // flag exists, and a release clears everything.
    function automatic kslpd_action_t take_action(int k);
        logic [FLAGS_W-1:0] f;
        kslpd_action_t      act;
        f   = key_flags[k];
        act = ACT_NONE;
        if (f[FL_FIRST]) begin
            f[FL_FIRST] = 1'b0;
            act = ACT_FIRST_PRESS;
        end else if (f[FL_SHOLD]) begin
            if (f[FL_SREL] || f[FL_LREL] || f[FL_LHOLD]) begin
                f[FL_SHOLD] = 1'b0;
            end
            act = ACT_SHORT_HOLD;
        end else if (f[FL_LHOLD]) begin
            if (f[FL_SREL] || f[FL_LREL]) begin
                f[FL_LHOLD] = 1'b0;
            end
            act = ACT_LONG_HOLD;
        end else if (f[FL_SREL] || f[FL_LREL]) begin
            if (f[FL_SREL]) begin
                act = ACT_SHORT_RELEASE;
            end else begin
                act = ACT_LONG_RELEASE;
            end
            f = '0;
        end
        key_flags[k] = f;
        return act;
    endfunction

    // Applies one input item to the predictor and returns its result item.
    function automatic kslpd_out_t classify_item(kslpd_in_t it);
        kslpd_out_t res;
        res = '0;
        case (it.kind)
            KIND_TICK: begin
                for (int k = 0; k < KEYS; k++) begin
                    if (enable_reg[k]) begin
                        time_key(k, it.key_levels[k], long_mode_reg[k]);
                    end else begin
                        key_flags[k] = '0;
                    end
                end
            end
            KIND_READ: begin
                res.action = take_action(it.key_index);
            end
            KIND_RESET: begin
                key_flags[it.key_index] = '0;
                hold_ms[it.key_index]   = '0;
            end
            KIND_CHECK: begin
            end
        endcase
        for (int k = 0; k < KEYS; k++) begin
            res.pending_mask[k] = |key_flags[k];
        end
        res.action_pending = |key_flags[it.key_index];
        return res;
    endfunction

    // Idle length for either side: mostly none, sometimes short, rarely long.
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Number of ticks a key is held: below, at, between and past the thresholds.
    function automatic int press_ticks(int s_ticks, int l_ticks);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, s_ticks + 1);
            1:       return s_ticks + $urandom_range(1, 3);
            2:       return $urandom_range(s_ticks + 1, l_ticks + 3);
            default: return l_ticks + $urandom_range(1, 4);
        endcase
    endfunction

    function automatic void push_item(kslpd_kind_t kind, logic [MASK_W-1:0] levels,
                                      logic [1:0] idx, bit hold_back);
        key_item_t e;
        e.item.kind       = kind;
        e.item.key_levels = levels;
        e.item.key_index  = idx;
        e.hold_back       = hold_back;
        key_item_q.push_back(e);
        items_sent_total++;
    endfunction

    task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
        if (mismatch_count < MAX_REPORTS) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
        end
        mismatch_count++;
    endtask

    // Register write; the mirror is updated at once since the block is idle.
    task automatic set_reg(kslpd_cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_SHORT_TIME: short_ms_reg  = value;
            CFG_LONG_TIME:  long_ms_reg   = value;
            CFG_LONG_MODE:  long_mode_reg = value[MASK_W-1:0];
            CFG_ENABLE:     enable_reg    = value[MASK_W-1:0];
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_W-1:0] short_ms, logic [CFG_W-1:0] long_ms,
                              logic [MASK_W-1:0] long_mode, logic [MASK_W-1:0] enable);
        set_reg(CFG_SHORT_TIME, short_ms);
        set_reg(CFG_LONG_TIME, long_ms);
        set_reg(CFG_LONG_MODE, {{(CFG_W-MASK_W){1'b0}}, long_mode});
        set_reg(CFG_ENABLE, {{(CFG_W-MASK_W){1'b0}}, enable});
    endtask

    // Waits until every queued item has produced its result, plus a margin.
    task automatic wait_idle();
        while (results_seen != items_sent_total) begin
            @(negedge aclk);
        end
        repeat (3) @(negedge aclk);
    endtask

    // Press and release sequences per key with reads, checks and resets mixed
    // in; a few ticks carry random levels as noise.
    task automatic run_random_phase(int count);
        bit                held [KEYS];
        int                left [KEYS];
        int                r;
        int                s_ticks;
        int                l_ticks;
        logic [MASK_W-1:0] lv;
        s_ticks = short_ms_reg / TICK_MS;
        l_ticks = long_ms_reg / TICK_MS;
        for (int k = 0; k < KEYS; k++) begin
            held[k] = 1'b0;
            left[k] = $urandom_range(0, 3);
        end
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                for (int k = 0; k < KEYS; k++) begin
                    if (left[k] == 0) begin
                        held[k] = !held[k];
                        left[k] = held[k] ? press_ticks(s_ticks, l_ticks)
                                          : $urandom_range(1, 4);
                    end
                    left[k]--;
                    lv[k] = held[k];
                end
                if ($urandom_range(0, 11) == 0) begin
                    lv = MASK_W'($urandom_range(0, 15));
                end
                push_item(KIND_TICK, lv, 2'($urandom_range(0, 3)),
                          $urandom_range(0, 99) == 0);
            end else if (r < 82) begin
                push_item(KIND_READ, MASK_W'($urandom_range(0, 15)),
                          2'($urandom_range(0, 3)), 1'b0);
            end else if (r < 94) begin
                push_item(KIND_CHECK, MASK_W'($urandom_range(0, 15)),
                          2'($urandom_range(0, 3)), 1'b0);
            end else begin
                push_item(KIND_RESET, MASK_W'($urandom_range(0, 15)),
                          2'($urandom_range(0, 3)), 1'b0);
            end
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Input driver: presents queued items at the falling edge.
    always @(negedge aclk) begin
        if ($urandom_range(0, 149) == 0) begin
            send_quiet <= !send_quiet;
        end
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fire) begin
            // The current item has not been taken yet, so it stays put.
        end else if (send_gap > 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (key_item_q.size() != 0 &&
                     !(key_item_q[0].hold_back && report_q.size() != 0)) begin
            s_data   <= key_item_q[0].item;
            s_valid  <= 1'b1;
            send_gap <= pick_gap(send_quiet);
            key_item_q.delete(0);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result side back-pressure.
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) begin
            recv_quiet <= !recv_quiet;
        end
        if (recv_hold > 0) begin
            m_ready   <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_ready   <= 1'b1;
            recv_hold <= pick_gap(recv_quiet);
        end
    end

    // Monitor: predict on input acceptance first, then check any result item.
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                report_q.push_back(classify_item(s_data));
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (report_q.size() == 0) begin
                    flag_mismatch("unexpected result item, action", 0, m_data.action);
                end else begin
                    want_res = report_q.pop_front();
                    if (m_data.action !== want_res.action) begin
                        flag_mismatch("action", want_res.action, m_data.action);
                    end
                    if (m_data.action_pending !== want_res.action_pending) begin
                        flag_mismatch("action_pending", want_res.action_pending,
                                      m_data.action_pending);
                    end
                    if (m_data.pending_mask !== want_res.pending_mask) begin
                        flag_mismatch("pending_mask", want_res.pending_mask,
                                      m_data.pending_mask);
                    end
                end
            end
        end
    end

    // Stimulus sequence.
    initial begin
        for (int k = 0; k < KEYS; k++) begin
            hold_ms[k]   = '0;
            key_flags[k] = '0;
        end
        short_ms_reg  = SHORT_TIME_RST;
        long_ms_reg   = LONG_TIME_RST;
        long_mode_reg = LONG_MODE_RST;
        enable_reg    = ENABLE_RST;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed walk with the reset thresholds: a short press on all keys,
        // reads through the short press actions, reset and check on single keys.
        push_item(KIND_CHECK, 4'hF, 2'd0, 1'b0);
        push_item(KIND_READ, 4'h0, 2'd3, 1'b0);
        repeat (6) push_item(KIND_TICK, 4'hF, 2'd1, 1'b0);
        push_item(KIND_READ, 4'h0, 2'd0, 1'b0);
        push_item(KIND_READ, 4'hF, 2'd0, 1'b0);
        push_item(KIND_TICK, 4'h0, 2'd2, 1'b1);
        repeat (3) push_item(KIND_READ, 4'h0, 2'd0, 1'b0);
        push_item(KIND_CHECK, 4'h0, 2'd1, 1'b0);
        push_item(KIND_RESET, 4'hF, 2'd1, 1'b0);
        push_item(KIND_CHECK, 4'h5, 2'd1, 1'b0);
        push_item(KIND_READ, 4'hA, 2'd2, 1'b0);
        push_item(KIND_TICK, 4'b1010, 2'd3, 1'b0);
        push_item(KIND_RESET, 4'h0, 2'd3, 1'b0);
        push_item(KIND_READ, 4'h0, 2'd3, 1'b0);
        push_item(KIND_TICK, 4'b0101, 2'd0, 1'b0);
        wait_idle();

        // Random phases across threshold and mask settings, extremes included.
        set_config(16'd20, 16'd60, 4'b0101, 4'hF);
        run_random_phase(70);
        wait_idle();
        set_config(16'd0, 16'd30, 4'hF, 4'b1011);
        run_random_phase(70);
        wait_idle();
        set_config(16'd30, 16'd0, 4'b1010, 4'hF);
        run_random_phase(70);
        wait_idle();
        set_config(16'd10, 16'd40, 4'hF, 4'b0110);
        run_random_phase(70);
        wait_idle();
        set_config(16'd20, 16'd50, 4'h0, 4'h0);
        run_random_phase(30);
        wait_idle();
        repeat (2) begin
            set_config(CFG_W'($urandom_range(0, 70)), CFG_W'($urandom_range(0, 200)),
                       MASK_W'($urandom_range(0, 15)), MASK_W'($urandom_range(0, 15)));
            run_random_phase(70);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && report_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (report_q.size() != 0) begin
                $error("%0d predicted result items never arrived", report_q.size());
            end
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/kslpd_pkg.sv
sv/kslpd_key.sv
sv/key_short_long_press_detector_top.sv
bench/testbench.sv
